FILE: src/sfmr_pkg.sv
// Shared types and constants for the stream first-match replace block.
package sfmr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int OUT_LIMIT       = 8;
  localparam int HOLD_DEPTH      = OUT_LIMIT - 1;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CNT_W           = $clog2(OUT_LIMIT + 1);
  localparam int IDX_W           = $clog2(OUT_LIMIT);
  localparam int HC_W            = $clog2(HOLD_DEPTH + 1);
  localparam int CFG_W           = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  // one step's worth of results: up to OUT_LIMIT bytes, first byte in bits 7:0
  typedef struct packed {
    logic [OUT_LIMIT*8-1:0] data;
    logic [CNT_W-1:0]       count;
    logic                   line_last;
  } burst_t;

endpackage

FILE: src/stream_first_match_replace_core.sv
// Top level of the stream first-match replace block.
// Takes one text byte per cycle and replaces the leftmost match of the pattern
// in each line. The front end classifies a byte in the cycle it is accepted and
// queues the results it causes as one request; the back end sends one result
// per cycle while out_stall is low, from a registered output stage; results
// reach it through the request queue. A passed-through byte yields one result;
// a match yields its replacement bytes, an insert those and then the byte (up
// to 8 per request), and the QUEUE_DEPTH-entry request queue absorbs incoming
// bytes meanwhile, so in_stall rises only when the queue is full. Sustained rate
// for pass-through text is one byte per cycle, bounded by the single result the output port moves per cycle.
module stream_first_match_replace_core import sfmr_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_text_byte,
  input  logic             in_line_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last
);

  logic   in_accept, q_push, q_pop, q_not_empty, q_full;
  burst_t q_wdata, q_head;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  sfmr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_accept    (in_accept),
    .in_text_byte (in_text_byte),
    .in_line_end  (in_line_end),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  sfmr_fifo #(.DEPTH(QUEUE_DEPTH_P)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  sfmr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (q_not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule

FILE: src/sfmr_front.sv
// Front end: configuration registers, match window and per-byte classification.
module sfmr_front import sfmr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_accept,
  input  logic [7:0]       in_text_byte,
  input  logic             in_line_end,
  output logic             q_push,
  output burst_t           q_data
);

  logic [63:0]      pattern_r;
  logic [3:0]       plen_r;
  logic [63:0]      rep_r;
  logic [3:0]       rlen_r;

  logic [7:0]       held_r   [HOLD_DEPTH];
  logic [7:0]       held_nxt [HOLD_DEPTH];
  logic [HC_W-1:0]  hc_r, hc_nxt;
  logic             done_r, done_nxt;
  logic             start_r, start_nxt;

  logic [7:0]       win [OUT_LIMIT];
  logic [3:0]       plen, rlen, n, room, cnt, keep, shift;
  logic             insert_mode, match;
  burst_t           burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= '0;
      rep_r     <= '0;
      rlen_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_r <= cfg_data[63:0];
        REG_PATTERN_LENGTH:     plen_r    <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  rep_r     <= cfg_data[63:0];
        REG_REPLACEMENT_LENGTH: rlen_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    plen = (plen_r > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : plen_r;
    rlen = (rlen_r > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) : rlen_r;
    n    = 4'(hc_r) + 4'd1;
  end

  always_comb begin
    logic [3:0] sidx;
    sidx = '0;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      win[i] = (HC_W'(i) < hc_r) ? held_r[i] : in_text_byte;
    end
    win[OUT_LIMIT-1] = in_text_byte;

    insert_mode = !done_r && start_r && (plen == 4'd0);
    room = in_line_end ? 4'(OUT_LIMIT - 1) : 4'(OUT_LIMIT);
    cnt  = (rlen > room) ? room : rlen;

    match = !done_r && (plen != 4'd0) && (n == plen);
    for (int i = 0; i < OUT_LIMIT; i++) begin
      if ((4'(i) < plen) && (win[i] != pattern_r[i*8 +: 8])) match = 1'b0;
    end

    if (!in_line_end && !done_r && (plen != 4'd0))
      keep = (n < plen - 4'd1) ? n : plen - 4'd1;
    else
      keep = 4'd0;
    shift = n - keep;

    for (int i = 0; i < OUT_LIMIT; i++) burst.data[i*8 +: 8] = win[i];
    burst.count     = CNT_W'(shift);
    burst.line_last = in_line_end;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      sidx = shift + 4'(i);
      held_nxt[i] = (sidx < 4'(OUT_LIMIT)) ? win[sidx[IDX_W-1:0]] : 8'd0;
    end
    hc_nxt   = HC_W'(keep);
    done_nxt = done_r;

    if (insert_mode) begin
      for (int i = 0; i < OUT_LIMIT; i++) begin
        if (4'(i) < cnt)       burst.data[i*8 +: 8] = rep_r[i*8 +: 8];
        else if (4'(i) == cnt) burst.data[i*8 +: 8] = in_text_byte;
        else                   burst.data[i*8 +: 8] = 8'd0;
      end
      burst.count = (cnt == 4'(OUT_LIMIT)) ? CNT_W'(OUT_LIMIT) : CNT_W'(cnt + 4'd1);
      held_nxt[0] = in_text_byte;
      hc_nxt      = (cnt == 4'(OUT_LIMIT)) ? HC_W'(1) : HC_W'(0);
      done_nxt    = 1'b1;
    end else if (match) begin
      burst.data  = rep_r;
      burst.count = CNT_W'(rlen);
      hc_nxt      = '0;
      done_nxt    = 1'b1;
    end

    if (in_line_end) begin
      hc_nxt    = '0;
      done_nxt  = 1'b0;
      start_nxt = 1'b1;
    end else begin
      start_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r    <= '0;
      done_r  <= 1'b0;
      start_r <= 1'b1;
    end else if (in_accept) begin
      hc_r    <= hc_nxt;
      done_r  <= done_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < HOLD_DEPTH; i++) held_r[i] <= held_nxt[i];
    end
  end

  assign q_push = in_accept && (in_line_end || (burst.count != '0));
  assign q_data = burst;

endmodule

FILE: src/sfmr_fifo.sv
// Short request queue between the front end and the output serializer.
module sfmr_fifo import sfmr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output burst_t head,
  output logic   not_empty,
  output logic   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  burst_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_QW-1:0]  cnt_r;

  function automatic logic [PTR_W-1:0] incr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_QW'(DEPTH));
  assign head      = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= incr(wr_r);
      if (pop)  rd_r <= incr(rd_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_QW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

endmodule

FILE: src/sfmr_back.sv
// Back end: walks each queued request and drives one result per cycle while out_stall is low.
module sfmr_back import sfmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  burst_t     head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             bvalid_r, bvalid_nxt;
  logic             last_r, last_nxt;
  logic             advance, final_one;

  always_comb begin
    advance    = !valid_r || !out_stall;
    final_one  = (head.count == '0) || (CNT_W'(idx_r) == head.count - CNT_W'(1));
    pop        = advance && head_valid && final_one;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    bvalid_nxt = bvalid_r;
    last_nxt   = last_r;
    if (advance) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        bvalid_nxt = (head.count != '0);
        byte_nxt   = bvalid_nxt ? head.data[idx_r*8 +: 8] : 8'd0;
        last_nxt   = head.line_last && final_one;
        idx_nxt    = final_one ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_last       = last_r;

endmodule

FILE: tb/stream_first_match_replace_core_tb.sv
// Testbench for stream_first_match_replace_core: directed table, random lines, scoreboard.
`timescale 1ns / 1ps

module stream_first_match_replace_core_tb import sfmr_pkg::*;;

  localparam int TOTAL_ITEMS    = 410;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int IDLE_LIMIT     = 3000;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } edit_result_t;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    cfg_reg_t     idx;
    logic [63:0]  data;
    logic [7:0]   ch;
    logic         le;
    bit           typed;
    edit_result_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_text_byte;
  logic             in_line_end;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte;
  logic             out_byte_valid;
  logic             out_last;

  // shadow of the block's registers and line state
  logic [63:0] pat_bytes = '0;
  logic [3:0]  pat_len = '0;
  logic [63:0] rep_bytes = '0;
  logic [3:0]  rep_len = '0;
  logic [7:0]  held_win [8] = '{default: 8'h00};
  logic [3:0]  held_cnt = '0;
  logic        replaced = 1'b0;
  logic        line_start = 1'b1;

  edit_result_t pending_results [$];
  edit_result_t step_results [$];
  edit_result_t typed_results [$];
  stim_row_t    directed_rows [$];

  edit_result_t got_result;
  edit_result_t want_result;
  int           mismatches = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  bit           hold_off_req = 1'b0;

  stream_first_match_replace_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_line_end    (in_line_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [3:0] len_pick();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      8: return 4'd8;
      9: return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [7:0] filler_char();
    int pos;
    pos = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return pat_bytes[pos*8 +: 8];
  endfunction

  function automatic void add_result(logic [7:0] c, logic v);
    if (step_results.size() < OUT_LIMIT) step_results.push_back(edit_result_t'{c, v, 1'b0});
  endfunction

  // results caused by one text byte; updates the shadow line state
  function automatic void edit_step(logic [7:0] ch, logic le);
    logic [7:0]   win [8];
    int           plen, rlen, hc, n, room, cnt, fit, keep, i;
    bit           hit;
    edit_result_t tail;
    step_results.delete();
    plen = (pat_len > 4'd8) ? 8 : int'(pat_len);
    rlen = (rep_len > 4'd8) ? 8 : int'(rep_len);
    hc = (held_cnt > 4'd7) ? 7 : int'(held_cnt);
    for (i = 0; i < hc; i++) win[i] = held_win[i];
    win[hc] = ch;
    n = hc + 1;
    if (!replaced && line_start && plen == 0) begin
      room = le ? OUT_LIMIT - 1 : OUT_LIMIT;
      cnt = (rlen > room) ? room : rlen;
      for (i = 0; i < cnt; i++) add_result(rep_bytes[i*8 +: 8], 1'b1);
      replaced = 1'b1;
      held_cnt = '0;
      if (le || step_results.size() + n <= OUT_LIMIT) begin
        for (i = 0; i < n; i++) add_result(win[i], 1'b1);
      end else begin
        fit = OUT_LIMIT - step_results.size();
        for (i = 0; i < fit; i++) add_result(win[i], 1'b1);
        for (i = fit; i < n; i++) held_win[i - fit] = win[i];
        held_cnt = 4'(n - fit);
      end
    end else begin
      hit = !replaced && plen > 0 && n == plen;
      for (i = 0; i < plen; i++) if (hit && win[i] != pat_bytes[i*8 +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rlen; i++) add_result(rep_bytes[i*8 +: 8], 1'b1);
        replaced = 1'b1;
        held_cnt = '0;
      end else begin
        keep = 0;
        if (!le && !replaced && plen > 0) keep = (n < plen - 1) ? n : plen - 1;
        for (i = 0; i < n - keep; i++) add_result(win[i], 1'b1);
        for (i = 0; i < keep; i++) held_win[i] = win[n - keep + i];
        held_cnt = 4'(keep);
      end
    end
    line_start = 1'b0;
    if (le) begin
      if (step_results.size() == 0) add_result(8'h00, 1'b0);
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
      held_cnt = '0;
      replaced = 1'b0;
      line_start = 1'b1;
    end
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, logic [63:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = val;
    row.ch = '0;
    row.le = 1'b0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_text(logic [7:0] ch, logic le, bit typed = 1'b0,
                                   edit_result_t want = '0);
    stim_row_t row;
    row.kind = ROW_TEXT;
    row.idx = REG_PATTERN_BYTES;
    row.data = '0;
    row.ch = ch;
    row.le = le;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_BYTES:      pat_bytes = val;
      REG_PATTERN_LENGTH:     pat_len = val[3:0];
      REG_REPLACEMENT_BYTES:  rep_bytes = val;
      REG_REPLACEMENT_LENGTH: rep_len = val[3:0];
      default: ;
    endcase
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // drives one text byte and queues the results it is expected to cause
  task automatic send_text(logic [7:0] ch, logic le);
    @(negedge clk);
    in_valid <= 1'b1;
    in_text_byte <= ch;
    in_line_end <= le;
    do @(posedge clk); while (in_stall);
    edit_step(ch, le);
    if (typed_results.size() != 0) begin
      foreach (typed_results[i]) pending_results.push_back(typed_results[i]);
      typed_results.delete();
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    items_sent++;
  endtask

  task automatic random_config();
    logic [63:0] pb, rb;
    logic [7:0]  base;
    int          k;
    base = 8'($urandom);
    case ($urandom_range(0, 5))
      0: pb = '0;
      1: pb = '1;
      2, 3: pb = {$urandom, $urandom};
      default: for (k = 0; k < 8; k++) pb[k*8 +: 8] = base + 8'($urandom_range(0, 2));
    endcase
    case ($urandom_range(0, 4))
      0: rb = '0;
      1: rb = '1;
      default: rb = {$urandom, $urandom};
    endcase
    write_reg(REG_PATTERN_BYTES, pb);
    write_reg(REG_PATTERN_LENGTH, 64'(len_pick()));
    write_reg(REG_REPLACEMENT_BYTES, rb);
    write_reg(REG_REPLACEMENT_LENGTH, 64'(len_pick()));
  endtask

  task automatic send_line();
    logic [7:0] text [$];
    int         kind, eff, cut, change_at, k;
    bit         no_gaps;
    eff = (pat_len > 4'd8) ? 8 : int'(pat_len);
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 4)) text.push_back(filler_char());
      cut = (kind < 6 || eff == 0) ? eff : $urandom_range(0, eff - 1);
      for (k = 0; k < cut; k++) text.push_back(pat_bytes[k*8 +: 8]);
      repeat ($urandom_range(0, 4)) text.push_back(filler_char());
      if (kind < 6 && $urandom_range(0, 2) == 0)
        for (k = 0; k < eff; k++) text.push_back(pat_bytes[k*8 +: 8]);
      if (text.size() == 0) text.push_back(filler_char());
    end
    change_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, text.size() - 1) : -1;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (k = 0; k < text.size(); k++) begin
      if (k == change_at && k > 0) begin
        drain_block();
        if ($urandom_range(0, 1) == 0) write_reg(REG_PATTERN_BYTES, {$urandom, $urandom});
        write_reg(REG_PATTERN_LENGTH, 64'(len_pick()));
      end
      send_text(text[k], k == text.size() - 1);
      if (!no_gaps && $urandom_range(0, 2) == 0) pause_sender(gap_len());
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    bit stall_val;
    int run_len;
    out_stall = 1'b0;
    forever begin
      if (hold_off_req) begin
        stall_val = 1'b1;
        run_len = HOLD_OFF_LEN;
        hold_off_req = 1'b0;
      end else begin
        stall_val = ($urandom_range(0, 2) == 0);
        run_len = gap_len();
      end
      @(negedge clk);
      out_stall <= stall_val;
      repeat (run_len - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = edit_result_t'{out_byte, out_byte_valid, out_last};
      if (pending_results.size() == 0) begin
        $display("%0t: expected no result, got byte=%h valid=%b last=%b", $time,
                 got_result.ch, got_result.has_char, got_result.last);
        mismatches++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result !== want_result) begin
          $display("%0t: mismatch expected byte=%h valid=%b last=%b, got byte=%h valid=%b last=%b",
                   $time, want_result.ch, want_result.has_char, want_result.last,
                   got_result.ch, got_result.has_char, got_result.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stream_first_match_replace_core_tb failed");
      $finish;
    end
  end

  initial begin
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PATTERN_BYTES;
    cfg_data = '0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_line_end = 1'b0;

    // registers at reset: empty insert, bytes pass through
    add_text(8'h00, 1'b1, 1'b1, edit_result_t'{8'h00, 1'b1, 1'b1});
    add_text(8'hff, 1'b1, 1'b1, edit_result_t'{8'hff, 1'b1, 1'b1});
    add_cfg(REG_PATTERN_BYTES, 64'h4241);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_cfg(REG_REPLACEMENT_BYTES, 64'h7a7978);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd3);
    add_text(8'h5a, 1'b0);
    add_text(8'h41, 1'b0);
    add_text(8'h42, 1'b0);
    add_text(8'h41, 1'b0);
    add_text(8'h42, 1'b1);
    // match with empty replacement at line end gives the empty marker
    add_cfg(REG_PATTERN_BYTES, 64'h51);
    add_cfg(REG_PATTERN_LENGTH, 64'd1);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd0);
    add_text(8'h51, 1'b1, 1'b1, edit_result_t'{8'h00, 1'b0, 1'b1});
    // lengths above the maximum clamp to 8
    add_cfg(REG_PATTERN_BYTES, 64'h3736353433323130);
    add_cfg(REG_PATTERN_LENGTH, 64'd15);
    add_cfg(REG_REPLACEMENT_BYTES, '1);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd12);
    for (int c = 0; c < 8; c++) add_text(8'h30 + 8'(c), c == 7);
    // insert burst, then the one-byte line overflow
    add_cfg(REG_PATTERN_LENGTH, 64'd0);
    add_cfg(REG_REPLACEMENT_BYTES, 64'h8877665544332211);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd8);
    add_text(8'h55, 1'b0);
    add_text(8'haa, 1'b1);
    add_text(8'h01, 1'b1);
    // empty pattern set mid-line: no insert
    add_cfg(REG_PATTERN_BYTES, 64'h4241);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd1);
    add_text(8'h43, 1'b0);
    add_cfg(REG_PATTERN_LENGTH, 64'd0);
    add_text(8'h41, 1'b0);
    add_text(8'h42, 1'b1);
    // pattern shortened below the held byte count
    add_cfg(REG_PATTERN_BYTES, 64'h44434241);
    add_cfg(REG_PATTERN_LENGTH, 64'd4);
    add_text(8'h41, 1'b0);
    add_text(8'h42, 1'b0);
    add_text(8'h43, 1'b0);
    add_cfg(REG_PATTERN_BYTES, 64'h5843);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_text(8'h58, 1'b0);
    add_text(8'h59, 1'b1);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        if (r == 0 || directed_rows[r-1].kind != ROW_CFG) drain_block();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        if (directed_rows[r].typed) typed_results.push_back(directed_rows[r].want);
        send_text(directed_rows[r].ch, directed_rows[r].le);
        if ($urandom_range(0, 2) == 0) pause_sender(gap_len());
      end
    end

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      drain_block();
      random_config();
      if (phase == 2) hold_off_req = 1'b1;
      repeat ($urandom_range(3, 8)) if (items_sent < TOTAL_ITEMS) send_line();
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("stream_first_match_replace_core_tb passed");
    else
      $display("stream_first_match_replace_core_tb failed");
    $finish;
  end

endmodule
